// ===== src/banded_step_motor_speed_controller_assert.svh =====
// Assertion macros for the speed controller; the bodies go away when SYNTH is set.
// Each macro expects aclk and aresetn in the enclosing module.
`ifndef BANDED_STEP_MOTOR_SPEED_CONTROLLER_ASSERT_SVH
`define BANDED_STEP_MOTOR_SPEED_CONTROLLER_ASSERT_SVH

`ifndef SYNTH
`define BSMSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BSMSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSMSC_ASSERT_IMP(lbl, ante, cons, msg)
`define BSMSC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/bsmsc_pkg.sv =====
package bsmsc_pkg;

    localparam int MOTOR_COUNT_DEF = 4;

    localparam int CMD_W    = 1;
    localparam int MOTOR_W  = 2;
    localparam int TIME_W   = 48;
    localparam int TARGET_W = 10;
    localparam int ERR_W    = 8;
    localparam int TMO_W    = 24;
    localparam int SPEED_W  = 24;
    localparam int DRIVE_W  = 16;
    localparam int DUTY_W   = 15;
    localparam int STEP_W   = 15;
    localparam int SCALE_W  = 16;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_ERR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TMO  = 3'd5;

    localparam logic [CMD_W-1:0] CMD_EVENT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CHECK = 1'b1;

    // the shared divider: the speed numerator fits in 29 bits
    localparam int DIV_W = 29;
    localparam logic [DIV_W-1:0] SPEED_NUM = 29'd341333333;

    // step = scale * 256 / 500 = scale * 64 / 125, taken as scale * ceil(2^29 / 125) >> 23
    localparam int RECIP_W = 23;
    localparam logic [RECIP_W-1:0] STEP_RECIP = 23'd4294968;

    localparam logic [SPEED_W-2:0] SPEED_MAX = 23'd8388607;
    localparam logic [DRIVE_W:0]   DRIVE_MAX = 17'd25600;
    localparam logic [STEP_W-1:0]  STOP_STEP = 15'd1792;
    localparam logic [TARGET_W-1:0] STOP_TARGET = 10'd30;

    // band factors in tenths of a percent
    localparam logic [5:0] BAND_FINE   = 6'd1;
    localparam logic [5:0] BAND_SMALL  = 6'd10;
    localparam logic [5:0] BAND_MID    = 6'd20;
    localparam logic [5:0] BAND_COARSE = 6'd50;

    localparam logic [TARGET_W-1:0] RST_TARGET_0 = 10'd10;
    localparam logic [TARGET_W-1:0] RST_TARGET_1 = 10'd30;
    localparam logic [TARGET_W-1:0] RST_TARGET_2 = 10'd60;
    localparam logic [TARGET_W-1:0] RST_TARGET_3 = 10'd90;
    localparam logic [ERR_W-1:0]    RST_ACC_ERR  = 8'd2;
    localparam logic [TMO_W-1:0]    RST_STALL_TMO = 24'd500000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic               need_step;
        logic               stop_step;
        logic               raise;
        logic [SCALE_W-1:0] scale;
    } plan_t;

endpackage

// ===== src/bsmsc_divider.sv =====
module bsmsc_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bsmsc_pkg::div_req_t                 req,
    output bsmsc_pkg::div_stat_t                stat,
    output logic [bsmsc_pkg::DIV_W-1:0]         quotient
);
    import bsmsc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;
    logic             fits;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = !trial[DIV_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == LAST_CNT);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== src/bsmsc_step.sv =====
module bsmsc_step (
    input  logic signed [bsmsc_pkg::SPEED_W-1:0]  speed,
    input  logic        [bsmsc_pkg::TARGET_W-1:0] target,
    input  logic        [bsmsc_pkg::ERR_W-1:0]    acc_err,
    input  logic signed [bsmsc_pkg::DRIVE_W-1:0]  drive,
    input  logic        [bsmsc_pkg::STEP_W-1:0]   step_val,
    input  logic                                  step_en,
    input  logic                                  raise,
    output bsmsc_pkg::plan_t                      plan,
    output logic signed [bsmsc_pkg::DRIVE_W-1:0]  drive_next
);
    import bsmsc_pkg::*;

    logic signed [SPEED_W:0] diff;
    logic        [SPEED_W:0] mag;
    logic        [16:0]      dist_rpm;
    logic        [20:0]      dist10;
    logic        [20:0]      tgt1;
    logic        [20:0]      tgt3;
    logic        [20:0]      tgt6;
    logic        [5:0]       band;
    logic        [15:0]      tb;
    logic signed [DRIVE_W:0] dsum;
    logic signed [DRIVE_W:0] step_s;

    always_comb begin
        diff   = $signed({speed[SPEED_W-1], speed})
               - $signed({7'b0, target, 8'b0});
        mag    = diff[SPEED_W] ? (SPEED_W+1)'(-diff) : diff;
        dist_rpm = mag[SPEED_W:8];
        dist10 = {1'b0, dist_rpm, 3'b0} + {3'b0, dist_rpm, 1'b0};
        tgt1   = {11'b0, target};
        tgt3   = {9'b0, target, 2'b0} - {11'b0, target};
        tgt6   = {tgt3[19:0], 1'b0};
        if (dist10 < tgt1) begin
            band = BAND_FINE;
        end else if (dist10 < tgt3) begin
            band = BAND_SMALL;
        end else if (dist10 < tgt6) begin
            band = BAND_MID;
        end else begin
            band = BAND_COARSE;
        end
        tb = {6'b0, target} * {10'b0, band};

        plan.need_step = dist_rpm > {9'b0, acc_err};
        plan.stop_step = (speed == '0) && ((drive == '0) || (target > STOP_TARGET));
        plan.raise     = diff[SPEED_W];
        plan.scale     = tb;
    end

    // add or take off the step, then clamp
    always_comb begin
        step_s = $signed({2'b0, step_val});
        dsum   = $signed({drive[DRIVE_W-1], drive});
        if (step_en) begin
            dsum = raise ? dsum + step_s : dsum - step_s;
        end
        if (dsum > $signed(DRIVE_MAX)) begin
            drive_next = DRIVE_W'(DRIVE_MAX);
        end else if (dsum < -$signed(DRIVE_MAX)) begin
            drive_next = DRIVE_W'(-$signed(DRIVE_MAX));
        end else begin
            drive_next = dsum[DRIVE_W-1:0];
        end
    end

endmodule

// ===== src/banded_step_motor_speed_controller.sv =====
// An accepted word moves through eval and then, as needed, the speed division, plan, step
// multiply and apply, before done; the speed division runs its 29 steps on the serial divider.
// A new word is taken the cycle after the result is registered, which then waits for
// m_tready on its own.
// Reset: aresetn low at a clock edge clears all motor state and restores register defaults.
module banded_step_motor_speed_controller #(
    parameter int MOTOR_COUNT = bsmsc_pkg::MOTOR_COUNT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [1:0] motor, [49:2] now_us, [50] forward_limit, [55:51] zero
    input  logic [bsmsc_pkg::S_DATA_W-1:0]       s_tdata,
    // [0] cmd
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] motor_out, [25:2] speed_q8, [40:26] forward_duty, [55:41] reverse_duty
    output logic [bsmsc_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bsmsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsmsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bsmsc_pkg::*;

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam logic [3:0] MOTOR_LIMIT = 4'(MOTOR_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE, ST_EVAL, ST_SPEED_DIV, ST_PLAN, ST_STEP_MUL, ST_APPLY, ST_DONE
    } state_t;

    state_t state_reg;

    logic [TARGET_W-1:0] target_reg [4];
    logic [ERR_W-1:0]    acc_err_reg;
    logic [TMO_W-1:0]    tmo_reg;

    logic [TIME_W-1:0]         last_reg  [MOTOR_COUNT];
    logic signed [SPEED_W-1:0] speed_reg [MOTOR_COUNT];
    logic signed [DRIVE_W-1:0] drive_reg [MOTOR_COUNT];

    logic [CMD_W-1:0]   cmd_reg;
    logic [MOTOR_W-1:0] motor_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               fwd_reg;

    logic signed [SPEED_W-1:0] spd_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      step_en_reg;
    logic                      raise_reg;
    logic [SCALE_W-1:0]        scale_reg;

    logic [SPEED_W-1:0] res_speed_reg;
    logic [DUTY_W-1:0]  res_fwd_reg;
    logic [DUTY_W-1:0]  res_rev_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [IDX_W-1:0]    idx;
    logic                motor_ok;
    logic [TIME_W-1:0]   elapsed;
    logic                eval_div;
    logic [SPEED_W-2:0]  mag_sat;
    logic [SCALE_W+RECIP_W-1:0] step_prod;

    div_req_t            div_req;
    div_stat_t           div_stat;
    logic [DIV_W-1:0]    div_quo;
    plan_t               plan;
    logic signed [DRIVE_W-1:0] drive_next;

    assign idx      = IDX_W'(motor_reg);
    assign motor_ok = {2'b0, motor_reg} < MOTOR_LIMIT;
    assign elapsed  = now_reg - last_reg[idx];
    assign eval_div = (state_reg == ST_EVAL) && motor_ok && (cmd_reg == CMD_EVENT)
                    && (elapsed != '0) && (elapsed[TIME_W-1:DIV_W] == '0);
    assign mag_sat  = (div_quo > {6'b0, SPEED_MAX}) ? SPEED_MAX : div_quo[SPEED_W-2:0];
    assign step_prod = {{RECIP_W{1'b0}}, scale_reg} * {{SCALE_W{1'b0}}, STEP_RECIP};

    always_comb begin
        div_req.start    = eval_div;
        div_req.dividend = SPEED_NUM;
        div_req.divisor  = elapsed[DIV_W-1:0];
    end

    bsmsc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    bsmsc_step u_step (
        .speed      (spd_reg),
        .target     (target_reg[motor_reg]),
        .acc_err    (acc_err_reg),
        .drive      (drive_reg[idx]),
        .step_val   (step_reg),
        .step_en    (step_en_reg),
        .raise      (raise_reg),
        .plan       (plan),
        .drive_next (drive_next)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg[0] <= RST_TARGET_0;
            target_reg[1] <= RST_TARGET_1;
            target_reg[2] <= RST_TARGET_2;
            target_reg[3] <= RST_TARGET_3;
            acc_err_reg   <= RST_ACC_ERR;
            tmo_reg       <= RST_STALL_TMO;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TARGET_0:  target_reg[0] <= cfg_data[TARGET_W-1:0];
                CFG_TARGET_1:  target_reg[1] <= cfg_data[TARGET_W-1:0];
                CFG_TARGET_2:  target_reg[2] <= cfg_data[TARGET_W-1:0];
                CFG_TARGET_3:  target_reg[3] <= cfg_data[TARGET_W-1:0];
                CFG_ACC_ERR:   acc_err_reg   <= cfg_data[ERR_W-1:0];
                CFG_STALL_TMO: tmo_reg       <= cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                last_reg[i]  <= '0;
                speed_reg[i] <= '0;
                drive_reg[i] <= '0;
            end
        end else begin
            // a result leaving in the done state is replaced there
            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= s_tuser;
                        motor_reg <= s_tdata[MOTOR_W-1:0];
                        now_reg   <= s_tdata[TIME_W+MOTOR_W-1:MOTOR_W];
                        fwd_reg   <= s_tdata[TIME_W+MOTOR_W];
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    step_en_reg <= 1'b0;
                    if (!motor_ok) begin
                        res_speed_reg <= '0;
                        res_fwd_reg   <= '0;
                        res_rev_reg   <= '0;
                        state_reg     <= ST_DONE;
                    end else if (cmd_reg == CMD_EVENT) begin
                        last_reg[idx] <= now_reg;
                        if (elapsed == '0) begin
                            spd_reg   <= fwd_reg ? $signed({1'b0, SPEED_MAX})
                                                 : -$signed({1'b0, SPEED_MAX});
                            state_reg <= ST_PLAN;
                        end else if (!eval_div) begin
                            spd_reg   <= '0;
                            state_reg <= ST_PLAN;
                        end else begin
                            state_reg <= ST_SPEED_DIV;
                        end
                    end else if (elapsed > {24'b0, tmo_reg}) begin
                        last_reg[idx] <= now_reg;
                        spd_reg       <= '0;
                        state_reg     <= ST_PLAN;
                    end else begin
                        spd_reg   <= speed_reg[idx];
                        state_reg <= ST_APPLY;
                    end
                end
                ST_SPEED_DIV: begin
                    if (div_stat.done) begin
                        spd_reg   <= fwd_reg ? $signed({1'b0, mag_sat})
                                             : -$signed({1'b0, mag_sat});
                        state_reg <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    raise_reg <= plan.raise;
                    scale_reg <= plan.scale;
                    if (!plan.need_step) begin
                        state_reg <= ST_APPLY;
                    end else if (plan.stop_step) begin
                        step_reg    <= STOP_STEP;
                        step_en_reg <= 1'b1;
                        state_reg   <= ST_APPLY;
                    end else begin
                        state_reg <= ST_STEP_MUL;
                    end
                end
                ST_STEP_MUL: begin
                    step_reg    <= step_prod[RECIP_W+STEP_W-1:RECIP_W];
                    step_en_reg <= 1'b1;
                    state_reg   <= ST_APPLY;
                end
                ST_APPLY: begin
                    drive_reg[idx] <= drive_next;
                    // zero drive forces the speed to zero
                    if (drive_next == '0) begin
                        speed_reg[idx] <= '0;
                        res_speed_reg  <= '0;
                    end else begin
                        speed_reg[idx] <= spd_reg;
                        res_speed_reg  <= spd_reg;
                    end
                    res_fwd_reg <= (drive_next > 0) ? drive_next[DUTY_W-1:0] : '0;
                    res_rev_reg <= (drive_next < 0) ? DUTY_W'(-drive_next) : '0;
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= {res_rev_reg, res_fwd_reg, res_speed_reg, motor_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `include "banded_step_motor_speed_controller_assert.svh"

    `BSMSC_ASSERT_IMP(a_ready_div_idle, s_tready, !div_stat.busy, "divider busy while ready")
    `BSMSC_ASSERT_NXT(a_accept_blocks, s_tvalid && s_tready, !s_tready, "ready after accept")
    `BSMSC_ASSERT_IMP(a_duty_one_side, m_tvalid,
        (m_tdata[40:26] == '0) || (m_tdata[55:41] == '0), "both duties nonzero")
    `BSMSC_ASSERT_IMP(a_done_in_div, div_stat.done, state_reg == ST_SPEED_DIV,
        "stray divider done")

endmodule
